FILE: rtl/core/sklt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key leaf table package
// Shared field widths, result codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sklt_pkg;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int POS_W  = 4;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_HIT,
        EM_MISS,
        EM_FULL,
        EM_BADPOS,
        EM_INS_OK,
        EM_READ,
        EM_CLEAR
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  rd_mid;
        logic  set_lo;
        logic  set_hi;
        logic  rd_shift;
        logic  shift_step;
        logic  write_new;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    ins_bad;
        logic    rd_bad;
        logic    ins_at_end;
        logic    shift_last;
        logic    range_empty;
        logic    key_eq;
        logic    key_lt;
    } t_stat;

endpackage

FILE: rtl/core/sklt_ram.sv
// ----------------------------------------------------------------------------
// Sorted key leaf table cell RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sklt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sklt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key leaf table controller
// Sequences find, insert, read and clear requests over the datapath.
// ----------------------------------------------------------------------------
module sklt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sklt_pkg::t_stat i_stat,
    output sklt_pkg::t_cmd  o_cmd,
    output logic           busy
);

    import sklt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_FCMP,
        S_SHIFT,
        S_WRNEW,
        S_RDOUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_FIND: begin
                        n_state = S_FIND;
                    end
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            w_cmd.emit = EM_FULL;
                            n_state    = S_IDLE;
                        end else if (i_stat.ins_bad) begin
                            w_cmd.emit = EM_BADPOS;
                            n_state    = S_IDLE;
                        end else if (i_stat.ins_at_end) begin
                            n_state = S_WRNEW;
                        end else begin
                            w_cmd.rd_shift = 1'b1;
                            n_state        = S_SHIFT;
                        end
                    end
                    ACT_READ: begin
                        if (i_stat.rd_bad) begin
                            w_cmd.emit = EM_BADPOS;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_RDOUT;
                        end
                    end
                    ACT_CLEAR: begin
                        w_cmd.emit = EM_CLEAR;
                        n_state    = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FIND: begin
                if (i_stat.range_empty) begin
                    w_cmd.emit = EM_MISS;
                    n_state    = S_IDLE;
                end else begin
                    w_cmd.rd_mid = 1'b1;
                    n_state      = S_FCMP;
                end
            end
            S_FCMP: begin
                if (i_stat.key_eq) begin
                    w_cmd.emit = EM_HIT;
                    n_state    = S_IDLE;
                end else if (i_stat.key_lt) begin
                    w_cmd.set_hi = 1'b1;
                    n_state      = S_FIND;
                end else begin
                    w_cmd.set_lo = 1'b1;
                    n_state      = S_FIND;
                end
            end
            S_SHIFT: begin
                w_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_WRNEW;
                end
            end
            S_WRNEW: begin
                w_cmd.write_new = 1'b1;
                w_cmd.emit      = EM_INS_OK;
                n_state         = S_IDLE;
            end
            S_RDOUT: begin
                w_cmd.emit = EM_READ;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd = w_cmd;
    assign busy  = r_busy;

endmodule

FILE: rtl/core/sklt_dp.sv
// ----------------------------------------------------------------------------
// Sorted key leaf table datapath
// Request registers, search bounds, shift pointer, cell count, cell RAM and
// the result registers.
// ----------------------------------------------------------------------------
module sklt_dp #(
    parameter int MAX_CELLS     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sklt_pkg::ACT_W-1:0]    i_action,
    input  logic [sklt_pkg::KEY_W-1:0]    i_search_key,
    input  logic [sklt_pkg::POS_W-1:0]    i_position,
    input  logic [sklt_pkg::PAY_W-1:0]    i_payload,
    input  sklt_pkg::t_cmd                i_cmd,
    output sklt_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [sklt_pkg::STAT_W-1:0]   o_status,
    output logic [sklt_pkg::IDX_W-1:0]    o_cell_index,
    output logic [sklt_pkg::KEY_W-1:0]    o_key_out,
    output logic [sklt_pkg::PAY_W-1:0]    o_payload_out,
    output logic [sklt_pkg::IDX_W-1:0]    o_cell_count
);

    import sklt_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = (PAYLOAD_WIDTH < PAY_W) ? PAYLOAD_WIDTH : PAY_W;
    localparam int RW = KEY_W + SW;

    t_action           r_action;
    logic [KEY_W-1:0]  r_key;
    logic [POS_W-1:0]  r_pos;
    logic [SW-1:0]     r_pay;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_ptr;
    logic [AW-1:0]     r_mid;

    logic              r_valid;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_idx;
    logic [KEY_W-1:0]  r_key_out;
    logic [PAY_W-1:0]  r_pay_out;

    logic [CW:0]       w_sum;
    logic [AW-1:0]     w_mid;
    logic [CW-1:0]     w_ptr_m1;
    logic [CW-1:0]     w_ptr_m2;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [RW-1:0]     w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [RW-1:0]     w_rdata;
    logic [KEY_W-1:0]  w_rkey;
    logic [SW-1:0]     w_rpay;

    logic [STAT_W-1:0] w_status;
    logic [IDX_W-1:0]  w_idx;
    logic [KEY_W-1:0]  w_key_out;
    logic [PAY_W-1:0]  w_pay_out;

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = AW'(w_sum >> 1);
    assign w_ptr_m1 = r_ptr - CW'(1);
    assign w_ptr_m2 = r_ptr - CW'(2);
    assign w_rkey   = w_rdata[RW-1:SW];
    assign w_rpay   = w_rdata[SW-1:0];

    always_comb begin
        if (i_cmd.rd_mid) begin
            w_raddr = w_mid;
        end else if (i_cmd.rd_shift) begin
            w_raddr = AW'(w_ptr_m1);
        end else if (i_cmd.shift_step) begin
            w_raddr = AW'(w_ptr_m2);
        end else begin
            w_raddr = AW'(r_pos);
        end
    end

    assign w_we    = i_cmd.shift_step | i_cmd.write_new;
    assign w_waddr = i_cmd.shift_step ? AW'(r_ptr) : AW'(r_pos);
    assign w_wdata = i_cmd.shift_step ? w_rdata : {r_key, r_pay};

    sklt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stat.action      = r_action;
    assign o_stat.full        = (r_count >= CW'(MAX_CELLS));
    assign o_stat.ins_bad     = (XW'(r_pos) > XW'(r_count));
    assign o_stat.rd_bad      = (XW'(r_pos) >= XW'(r_count));
    assign o_stat.ins_at_end  = (XW'(r_ptr) == XW'(r_pos));
    assign o_stat.shift_last  = (XW'(w_ptr_m1) == XW'(r_pos));
    assign o_stat.range_empty = (r_lo == r_hi);
    assign o_stat.key_eq      = (w_rkey == r_key);
    assign o_stat.key_lt      = (r_key < w_rkey);

    always_comb begin
        n_count = r_count;
        if (i_cmd.emit == EM_CLEAR) begin
            n_count = '0;
        end else if (i_cmd.write_new) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        w_status  = ST_OK;
        w_idx     = IDX_W'(r_pos);
        w_key_out = '0;
        w_pay_out = '0;
        case (i_cmd.emit)
            EM_HIT: begin
                w_idx = IDX_W'(r_mid);
            end
            EM_MISS: begin
                w_status = ST_MISS;
                w_idx    = IDX_W'(r_lo);
            end
            EM_FULL: begin
                w_status = ST_FULL;
            end
            EM_BADPOS: begin
                w_status = ST_BADPOS;
            end
            EM_READ: begin
                w_key_out = w_rkey;
                w_pay_out = PAY_W'(w_rpay);
            end
            EM_CLEAR: begin
                w_status = ST_CLEARED;
                w_idx    = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= (i_cmd.emit != EM_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_key    <= i_search_key;
            r_pos    <= i_position;
            r_pay    <= SW'(i_payload);
            r_lo     <= '0;
            r_hi     <= r_count;
            r_ptr    <= r_count;
        end else begin
            if (i_cmd.set_lo) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
            if (i_cmd.set_hi) begin
                r_hi <= CW'(r_mid);
            end
            if (i_cmd.shift_step) begin
                r_ptr <= w_ptr_m1;
            end
        end
        if (i_cmd.rd_mid) begin
            r_mid <= w_mid;
        end
        if (i_cmd.emit != EM_NONE) begin
            r_status  <= w_status;
            r_idx     <= w_idx;
            r_key_out <= w_key_out;
            r_pay_out <= w_pay_out;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_cell_index  = r_idx;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_pay_out;
    assign o_cell_count  = IDX_W'(r_count);

endmodule

FILE: rtl/core/sorted_key_leaf_table_top.sv
// ----------------------------------------------------------------------------
// Sorted key leaf table
// Find is a binary search that probes the middle cell of the search bounds
// until a hit or an empty range; insert moves each cell from the position
// up by one (cell count minus position cells), then writes the new cell.
// The cell RAM has a single read port; one request is handled at a time and
// the next request is taken in the cycle the result strobe is high.
// Synchronous active-low reset empties the leaf; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_leaf_table_top #(
    parameter int MAX_CELLS     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [sklt_pkg::ACT_W-1:0]  i_action,
    input  logic [sklt_pkg::KEY_W-1:0]  i_search_key,
    input  logic [sklt_pkg::POS_W-1:0]  i_position,
    input  logic [sklt_pkg::PAY_W-1:0]  i_payload,
    output logic                        busy,
    output logic                        o_valid,
    output logic [sklt_pkg::STAT_W-1:0] o_status,
    output logic [sklt_pkg::IDX_W-1:0]  o_cell_index,
    output logic [sklt_pkg::KEY_W-1:0]  o_key_out,
    output logic [sklt_pkg::PAY_W-1:0]  o_payload_out,
    output logic [sklt_pkg::IDX_W-1:0]  o_cell_count
);

    import sklt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sklt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    sklt_dp #(
        .MAX_CELLS     (MAX_CELLS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_search_key  (i_search_key),
        .i_position    (i_position),
        .i_payload     (i_payload),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_cell_index  (o_cell_index),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_cell_count  (o_cell_count)
    );

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe held for more than one cycle.");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result strobe while the block is still busy.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_cell_count == IDX_W'(MAX_CELLS)))
        else $error("Full status reported with a leaf that is not full.");

endmodule
